// File: rtl/core/rwsp_pkg.sv
`default_nettype none

package rwsp_pkg;

    // four-character tags, first byte received in the top bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_LEN  = 32'd16;
    localparam logic [7:0]  PCM_CODE = 8'd1;
    localparam logic [7:0]  MONO     = 8'd1;
    localparam logic [7:0]  BITS8    = 8'd8;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_HEADER  = 3'd1;
    localparam logic [2:0] ERR_FMT_SIZE    = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ERR_SHORT_DATA  = 3'd4;
    localparam logic [2:0] ERR_MISSING     = 3'd5;

    localparam int TDATA_W = 80;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic        sample_valid;
        logic [7:0]  sample_byte;
        logic        chunk_first;
        logic        done_res;
        logic        accepted;
        logic [2:0]  error_code;
        logic [31:0] sample_rate;
        logic [31:0] sample_count;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/rwsp_parser.sv
`default_nettype none

module rwsp_parser (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   beat_fire,
    input  wire  [7:0]            byte_value,
    input  wire                   final_byte,
    output logic                  res_valid,
    output rwsp_pkg::result_t     res
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHDR   = 3'd1;
    localparam logic [2:0] PH_FMT    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_FAILED = 3'd5;

    localparam logic [7:0] PCM_CODE_C = rwsp_pkg::PCM_CODE;
    localparam logic [7:0] MONO_C     = rwsp_pkg::MONO;
    localparam logic [7:0] BITS8_C    = rwsp_pkg::BITS8;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] acc_reg, acc_next;
    logic        bad_reg, bad_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] frame_reg, frame_next;
    logic        seen_fmt_reg, seen_fmt_next;
    logic        seen_data_reg, seen_data_next;
    logic [2:0]  fail_reg, fail_next;

    logic [31:0] cnt_inc;
    logic [31:0] tag_shifted;
    logic [31:0] len_merged;
    logic [31:0] acc_merged;
    logic [3:0]  fmt_idx;
    logic        fmt_mismatch;
    logic        have_sample;
    logic        first;
    logic [2:0]  verdict;

    assign cnt_inc     = cnt_reg + 32'd1;
    assign tag_shifted = {tag_reg[23:0], byte_value};
    assign fmt_idx     = cnt_reg[3:0];

    always_comb begin
        len_merged = len_reg;
        case (cnt_reg[1:0])
            2'd0:    len_merged[7:0]   = byte_value;
            2'd1:    len_merged[15:8]  = byte_value;
            2'd2:    len_merged[23:16] = byte_value;
            default: len_merged[31:24] = byte_value;
        endcase
        acc_merged = acc_reg;
        case (fmt_idx[1:0])
            2'd0:    acc_merged[7:0]   = byte_value;
            2'd1:    acc_merged[15:8]  = byte_value;
            2'd2:    acc_merged[23:16] = byte_value;
            default: acc_merged[31:24] = byte_value;
        endcase
        case (fmt_idx) inside
            4'd0:          fmt_mismatch = (byte_value != PCM_CODE_C);
            4'd2:          fmt_mismatch = (byte_value != MONO_C);
            4'd14:         fmt_mismatch = (byte_value != BITS8_C);
            4'd1, 4'd3,
            4'd15:         fmt_mismatch = (byte_value != 8'd0);
            default:       fmt_mismatch = 1'b0;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        rate_next      = rate_reg;
        frame_next     = frame_reg;
        seen_fmt_next  = seen_fmt_reg;
        seen_data_next = seen_data_reg;
        fail_next      = fail_reg;
        have_sample    = 1'b0;
        first          = 1'b0;

        unique case (phase_reg) inside
            PH_HEADER: begin
                tag_next = tag_shifted;
                if ((cnt_reg == 32'd3 && tag_shifted != rwsp_pkg::TAG_RIFF) ||
                    (cnt_reg == 32'd11 && tag_shifted != rwsp_pkg::TAG_WAVE)) begin
                    fail_next  = rwsp_pkg::ERR_BAD_HEADER;
                    phase_next = PH_FAILED;
                end else if (cnt_reg == 32'd11) begin
                    phase_next = PH_CHDR;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_CHDR: begin
                if (cnt_reg < 32'd4) begin
                    tag_next = tag_shifted;
                    if (cnt_reg == 32'd0) begin
                        len_next = '0;
                    end
                    cnt_next = cnt_inc;
                end else begin
                    len_next = len_merged;
                    if (cnt_reg == 32'd7) begin
                        cnt_next = '0;
                        if (tag_reg == rwsp_pkg::TAG_FMT) begin
                            if (len_merged != rwsp_pkg::FMT_LEN) begin
                                fail_next  = rwsp_pkg::ERR_FMT_SIZE;
                                phase_next = PH_FAILED;
                            end else begin
                                acc_next   = '0;
                                bad_next   = 1'b0;
                                phase_next = PH_FMT;
                            end
                        end else if (tag_reg == rwsp_pkg::TAG_DATA) begin
                            frame_next     = len_merged;
                            seen_data_next = 1'b1;
                            phase_next     = (len_merged == 32'd0) ? PH_CHDR : PH_DATA;
                        end else begin
                            phase_next = (len_merged == 32'd0) ? PH_CHDR : PH_SKIP;
                        end
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            PH_FMT: begin
                bad_next = bad_reg | fmt_mismatch;
                if (fmt_idx[3:2] == 2'b01) begin
                    acc_next = acc_merged;
                end
                if (fmt_idx == 4'd15) begin
                    rate_next = acc_reg;
                    if (bad_reg | fmt_mismatch) begin
                        fail_next  = rwsp_pkg::ERR_UNSUPPORTED;
                        phase_next = PH_FAILED;
                    end else begin
                        seen_fmt_next = 1'b1;
                        phase_next    = PH_CHDR;
                        cnt_next      = '0;
                    end
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_DATA, PH_SKIP: begin
                have_sample = (phase_reg == PH_DATA);
                first       = (cnt_reg == 32'd0);
                if (cnt_inc == len_reg) begin
                    phase_next = PH_CHDR;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // closing verdict on the final beat
    always_comb begin
        verdict = fail_next;
        if (verdict == rwsp_pkg::ERR_NONE) begin
            if (phase_next == PH_HEADER)    verdict = rwsp_pkg::ERR_BAD_HEADER;
            else if (phase_next == PH_FMT)  verdict = rwsp_pkg::ERR_FMT_SIZE;
            else if (phase_next == PH_DATA) verdict = rwsp_pkg::ERR_SHORT_DATA;
        end
        if (verdict == rwsp_pkg::ERR_NONE &&
            (!seen_fmt_next || !seen_data_next ||
             rate_next == 32'd0 || frame_next == 32'd0)) begin
            verdict = rwsp_pkg::ERR_MISSING;
        end
    end

    always_comb begin
        res_valid          = have_sample | final_byte;
        res.sample_valid   = have_sample;
        res.sample_byte    = have_sample ? byte_value : 8'd0;
        res.chunk_first    = have_sample & first;
        res.done_res       = final_byte;
        res.accepted       = final_byte && (verdict == rwsp_pkg::ERR_NONE);
        res.error_code     = final_byte ? verdict : rwsp_pkg::ERR_NONE;
        res.sample_rate    = final_byte ? rate_next : 32'd0;
        res.sample_count   = final_byte ? frame_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_fire && final_byte)) begin
            // a final beat returns the parser to its reset state
            phase_reg     <= PH_HEADER;
            cnt_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            rate_reg      <= '0;
            frame_reg     <= '0;
            seen_fmt_reg  <= 1'b0;
            seen_data_reg <= 1'b0;
            fail_reg      <= rwsp_pkg::ERR_NONE;
        end else if (beat_fire) begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            rate_reg      <= rate_next;
            frame_reg     <= frame_next;
            seen_fmt_reg  <= seen_fmt_next;
            seen_data_reg <= seen_data_next;
            fail_reg      <= fail_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rwsp_out_reg.sv
`default_nettype none

module rwsp_out_reg (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                beat_fire,
    input  wire                                res_valid,
    input  rwsp_pkg::result_t                  res,
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [rwsp_pkg::TDATA_W-1:0]       m_tdata,
    output logic [rwsp_pkg::TUSER_W-1:0]       m_tuser,
    output logic                               m_tlast
);

    logic              valid_reg, valid_next;
    rwsp_pkg::result_t data_reg;

    // take a new beat whenever the held one is gone or leaves this cycle
    assign in_ready   = !valid_reg || m_tready;
    assign valid_next = in_ready ? (beat_fire & res_valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && beat_fire && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, data_reg.sample_count, data_reg.sample_rate,
                       data_reg.error_code, data_reg.accepted, data_reg.sample_byte};
    assign m_tuser  = {data_reg.chunk_first, data_reg.sample_valid};
    assign m_tlast  = data_reg.done_res;

endmodule

`default_nettype wire

// File: rtl/core/riff_wave_stream_parser.sv
// A result beat appears on m_ in the cycle after the input beat that causes it.
// Throughput: one file byte per cycle; the next byte is taken while a result waits,
// as long as the output register drains (s_tready = !m_tvalid || m_tready).
// Reset: aresetn low clears the parser to the file-header phase and empties the
// output register. The final byte of a file also returns the parser to that state.
`default_nettype none

module riff_wave_stream_parser (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,  // [7:0] byte_value
    input  wire                              s_tlast,  // final_byte
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [7:0] sample_byte, [8] accepted, [11:9] error_code, [43:12] sample_rate,
    // [75:44] sample_count, [79:76] zero
    output logic [rwsp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [rwsp_pkg::TUSER_W-1:0]     m_tuser,  // [0] sample_valid, [1] chunk_first
    output logic                             m_tlast   // done_res
);

    logic              beat_fire;
    logic              res_valid;
    rwsp_pkg::result_t res;

    assign beat_fire = s_tvalid && s_tready;

    rwsp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_fire  (beat_fire),
        .byte_value (s_tdata),
        .final_byte (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    rwsp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (beat_fire),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
